FILE: rtl/core/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every edge, reset included.
`define SWK_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

// Checked only outside reset.
`define SWK_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`endif

FILE: rtl/core/swk_pkg.sv
package swk_pkg;

    localparam int ANGLE_COUNTS  = 8192;
    localparam int ANGLE_BITS    = $clog2(ANGLE_COUNTS);
    localparam int CORDIC_STAGES = 16;
    localparam int NUM_WHEELS    = 4;

    localparam int VEL_W      = 16;
    localparam int DIM_W      = 12;
    localparam int GAIN_W     = 20;
    localparam int OFFSET_W   = 13;
    localparam int SPEED_W    = 15;
    localparam int STEER_W    = 13;
    localparam int CFG_DATA_W = 20;
    localparam int CFG_IDX_W  = 3;

    // front end widths
    localparam int VK_W   = 26;   // velocity times 1000
    localparam int YK_W   = 28;   // yaw rate times a half distance
    localparam int COMP_W = 29;   // wheel velocity component
    localparam int MAG_W  = 28;   // its absolute value
    localparam int SQ_W   = 2 * MAG_W;

    // square root chain
    localparam int RAD_W       = 58;
    localparam int ROOT_W      = RAD_W / 2;
    localparam int REM_W       = ROOT_W + 2;
    localparam int SQRT_STAGES = ROOT_W;

    // heading
    localparam int CORDIC_W    = 56;
    localparam int CORDIC_FRAC = 24;
    localparam int ANGLE_W     = 32;
    localparam int SHIFT_W     = 5;
    localparam logic [ANGLE_W-1:0] HALF_TURN = {1'b1, {(ANGLE_W-1){1'b0}}};

    // rpm scaling: floor(mag * gain / 2^16 / 1000), saturated to RPM_MAX
    localparam int PROD_W     = ROOT_W + GAIN_W;
    localparam int GAIN_SHIFT = 16;
    localparam int Q_W        = PROD_W - GAIN_SHIFT;
    localparam int QL_W       = 25;
    localparam int RECIP_W    = 26;
    localparam int QM_W       = QL_W + RECIP_W;
    localparam int DIV_SHIFT  = 35;
    localparam int REMD_W     = 26;
    localparam logic [RECIP_W-1:0] DIV_RECIP = 26'd34359738;
    localparam logic [REMD_W-1:0]  RPM_DIV   = 26'd1000;
    localparam logic [Q_W-1:0]     SAT_LIMIT = 33'd32768000;
    localparam logic [SPEED_W-1:0] RPM_MAX   = 15'd32767;

    localparam int FRONT_STAGES = 4;
    localparam int BACK_STAGES  = 3;
    localparam int PIPE_STAGES  = FRONT_STAGES + SQRT_STAGES + BACK_STAGES;

    // wheel order FR, FL, RL, RR; bit set where the coordinate is positive
    localparam logic [NUM_WHEELS-1:0] WHEEL_X_POS = 4'b1001;
    localparam logic [NUM_WHEELS-1:0] WHEEL_Y_POS = 4'b0011;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_HALF_WHEELBASE = 3'd0,
        REG_HALF_TRACK     = 3'd1,
        REG_RPM_GAIN       = 3'd2,
        REG_OFFSET_FR      = 3'd3,
        REG_OFFSET_FL      = 3'd4,
        REG_OFFSET_RL      = 3'd5,
        REG_OFFSET_RR      = 3'd6
    } cfg_reg_t;

    typedef struct packed {
        logic [RAD_W-1:0]           rad;
        logic [REM_W-1:0]           rem;
        logic [ROOT_W-1:0]          root;
        logic signed [CORDIC_W-1:0] x;
        logic signed [CORDIC_W-1:0] y;
        logic [ANGLE_W-1:0]         z;
        logic                       zero;
    } cell_data_t;

    function automatic logic [ANGLE_W-1:0] atan_angle(input logic [SHIFT_W-1:0] i);
        logic [ANGLE_W-1:0] a;
        case (i)
            5'd0:    a = 32'h20000000;
            5'd1:    a = 32'h12E4051E;
            5'd2:    a = 32'h09FB385B;
            5'd3:    a = 32'h051111D4;
            5'd4:    a = 32'h028B0D43;
            5'd5:    a = 32'h0145D7E1;
            5'd6:    a = 32'h00A2F61E;
            5'd7:    a = 32'h00517C55;
            5'd8:    a = 32'h0028BE53;
            5'd9:    a = 32'h00145F2F;
            5'd10:   a = 32'h000A2F98;
            5'd11:   a = 32'h000517CC;
            5'd12:   a = 32'h00028BE6;
            5'd13:   a = 32'h000145F3;
            5'd14:   a = 32'h0000A2FA;
            5'd15:   a = 32'h0000517D;
            5'd16:   a = 32'h000028BE;
            5'd17:   a = 32'h0000145F;
            5'd18:   a = 32'h00000A30;
            5'd19:   a = 32'h00000518;
            5'd20:   a = 32'h0000028C;
            5'd21:   a = 32'h00000146;
            5'd22:   a = 32'h000000A3;
            5'd23:   a = 32'h00000051;
            default: a = '0;
        endcase
        return a;
    endfunction

endpackage

FILE: rtl/core/swk_front.sv
module swk_front
    import swk_pkg::*;
(
    input  logic                           clk,
    input  logic [FRONT_STAGES-1:0]        en,
    input  logic signed [VEL_W-1:0]        vel_x_mm_s,
    input  logic signed [VEL_W-1:0]        vel_y_mm_s,
    input  logic signed [VEL_W-1:0]        yaw_rate_mrad_s,
    input  logic [DIM_W-1:0]               half_wheelbase,
    input  logic [DIM_W-1:0]               half_track,
    output cell_data_t                     head [NUM_WHEELS]
);

    localparam logic signed [VK_W-1:0] VEL_SCALE = 26'sd1000;

    logic signed [VK_W-1:0]     vx_k_reg, vy_k_reg;
    logic signed [YK_W-1:0]     yaw_w_reg, yaw_t_reg;
    logic signed [COMP_W-1:0]   ix_reg [NUM_WHEELS];
    logic signed [COMP_W-1:0]   iy_reg [NUM_WHEELS];
    logic [SQ_W-1:0]            sqx_reg [NUM_WHEELS];
    logic [SQ_W-1:0]            sqy_reg [NUM_WHEELS];
    logic signed [CORDIC_W-1:0] x_reg [NUM_WHEELS];
    logic signed [CORDIC_W-1:0] y_reg [NUM_WHEELS];
    logic                       turn_reg [NUM_WHEELS];
    logic                       zero_reg [NUM_WHEELS];
    cell_data_t                 head_reg [NUM_WHEELS];

    // products shared by all wheels
    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            vx_k_reg  <= $signed({{(VK_W-VEL_W){vel_x_mm_s[VEL_W-1]}}, vel_x_mm_s}) * VEL_SCALE;
            vy_k_reg  <= $signed({{(VK_W-VEL_W){vel_y_mm_s[VEL_W-1]}}, vel_y_mm_s}) * VEL_SCALE;
            yaw_w_reg <= $signed({{(YK_W-VEL_W){yaw_rate_mrad_s[VEL_W-1]}}, yaw_rate_mrad_s})
                       * $signed({{(YK_W-DIM_W){1'b0}}, half_wheelbase});
            yaw_t_reg <= $signed({{(YK_W-VEL_W){yaw_rate_mrad_s[VEL_W-1]}}, yaw_rate_mrad_s})
                       * $signed({{(YK_W-DIM_W){1'b0}}, half_track});
        end
    end

    for (genvar w = 0; w < NUM_WHEELS; w++)
    begin : g_wheel
        logic signed [COMP_W-1:0]   vxe, vye, ywe, yte;
        logic [COMP_W-1:0]          ax, ay;
        logic signed [CORDIC_W-1:0] xs, ys;

        always_comb
        begin
            vxe = $signed({{(COMP_W-VK_W){vx_k_reg[VK_W-1]}}, vx_k_reg});
            vye = $signed({{(COMP_W-VK_W){vy_k_reg[VK_W-1]}}, vy_k_reg});
            ywe = $signed({{(COMP_W-YK_W){yaw_w_reg[YK_W-1]}}, yaw_w_reg});
            yte = $signed({{(COMP_W-YK_W){yaw_t_reg[YK_W-1]}}, yaw_t_reg});
            ax  = ix_reg[w][COMP_W-1] ? COMP_W'(-ix_reg[w]) : COMP_W'(ix_reg[w]);
            ay  = iy_reg[w][COMP_W-1] ? COMP_W'(-iy_reg[w]) : COMP_W'(iy_reg[w]);
            xs  = $signed({{(CORDIC_W-COMP_W-CORDIC_FRAC){ix_reg[w][COMP_W-1]}},
                           ix_reg[w], {CORDIC_FRAC{1'b0}}});
            ys  = $signed({{(CORDIC_W-COMP_W-CORDIC_FRAC){iy_reg[w][COMP_W-1]}},
                           iy_reg[w], {CORDIC_FRAC{1'b0}}});
        end

        always_ff @(posedge clk)
        begin
            if (en[1])
            begin
                ix_reg[w] <= WHEEL_Y_POS[w] ? vxe - ywe : vxe + ywe;
                iy_reg[w] <= WHEEL_X_POS[w] ? vye + yte : vye - yte;
            end
            if (en[2])
            begin
                sqx_reg[w] <= ax[MAG_W-1:0] * ax[MAG_W-1:0];
                sqy_reg[w] <= ay[MAG_W-1:0] * ay[MAG_W-1:0];
                // turn a vector in the left half plane by half a turn
                turn_reg[w] <= ix_reg[w][COMP_W-1];
                x_reg[w]    <= ix_reg[w][COMP_W-1] ? -xs : xs;
                y_reg[w]    <= ix_reg[w][COMP_W-1] ? -ys : ys;
                zero_reg[w] <= (ix_reg[w] == '0) && (iy_reg[w] == '0);
            end
            if (en[3])
            begin
                head_reg[w].rad  <= RAD_W'({1'b0, sqx_reg[w]} + {1'b0, sqy_reg[w]});
                head_reg[w].rem  <= '0;
                head_reg[w].root <= '0;
                head_reg[w].x    <= x_reg[w];
                head_reg[w].y    <= y_reg[w];
                head_reg[w].z    <= turn_reg[w] ? HALF_TURN : '0;
                head_reg[w].zero <= zero_reg[w];
            end
        end

        assign head[w] = head_reg[w];
    end

endmodule

FILE: rtl/core/swk_cell.sv
module swk_cell
    import swk_pkg::*;
(
    input  logic               clk,
    input  logic               en,
    input  logic [SHIFT_W-1:0] stage,
    input  cell_data_t         d_in,
    output cell_data_t         d_out
);

    logic [REM_W+1:0]           rem2, trial;
    logic                       take;
    logic signed [CORDIC_W-1:0] xi, yi, dx, dy;
    cell_data_t                 d_next, d_reg;

    always_comb
    begin
        // one root bit per cell
        rem2  = {d_in.rem, d_in.rad[RAD_W-1 -: 2]};
        trial = {2'b00, d_in.root, 2'b01};
        take  = (rem2 >= trial);

        xi = d_in.x;
        yi = d_in.y;
        dx = yi >>> stage;
        dy = xi >>> stage;

        d_next      = d_in;
        d_next.rad  = {d_in.rad[RAD_W-3:0], 2'b00};
        d_next.rem  = take ? REM_W'(rem2 - trial) : REM_W'(rem2);
        d_next.root = {d_in.root[ROOT_W-2:0], take};

        // one rotation per cell for the first CORDIC_STAGES cells
        if (stage < SHIFT_W'(CORDIC_STAGES))
        begin
            if (!yi[CORDIC_W-1])
            begin
                d_next.x = xi + dx;
                d_next.y = yi - dy;
                d_next.z = d_in.z + atan_angle(stage);
            end
            else
            begin
                d_next.x = xi - dx;
                d_next.y = yi + dy;
                d_next.z = d_in.z - atan_angle(stage);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_reg <= d_next;
        end
    end

    assign d_out = d_reg;

endmodule

FILE: rtl/core/swk_back.sv
module swk_back
    import swk_pkg::*;
(
    input  logic                   clk,
    input  logic [BACK_STAGES-1:0] en,
    input  cell_data_t             d_in,
    input  logic [GAIN_W-1:0]      gain,
    input  logic [OFFSET_W-1:0]    offset,
    output logic [SPEED_W-1:0]     speed,
    output logic [STEER_W-1:0]     steer
);

    logic [PROD_W-1:0]     prod_reg;
    logic [STEER_W-1:0]    steer_e_reg, steer_f_reg, steer_reg;
    logic [Q_W-1:0]        q;
    logic                  sat_reg;
    logic [QL_W-1:0]       q_low_reg;
    logic [QM_W-1:0]       qm_reg;
    logic [SPEED_W-1:0]    r0, speed_reg;
    logic [REMD_W-1:0]     remd;
    logic [ANGLE_BITS-1:0] cnt, off_mod;

    always_comb
    begin
        cnt     = d_in.zero ? '0 : d_in.z[ANGLE_W-1 -: ANGLE_BITS];
        off_mod = ANGLE_BITS'(offset);
        q       = prod_reg[PROD_W-1:GAIN_SHIFT];
        r0      = qm_reg[DIV_SHIFT +: SPEED_W];
        remd    = REMD_W'(q_low_reg) - REMD_W'(REMD_W'(r0) * RPM_DIV);
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            prod_reg    <= PROD_W'(d_in.root) * PROD_W'(gain);
            steer_e_reg <= STEER_W'(ANGLE_BITS'(cnt - off_mod));
        end
        if (en[1])
        begin
            sat_reg     <= (q >= SAT_LIMIT);
            q_low_reg   <= q[QL_W-1:0];
            qm_reg      <= QM_W'(q[QL_W-1:0]) * QM_W'(DIV_RECIP);
            steer_f_reg <= steer_e_reg;
        end
        if (en[2])
        begin
            // reciprocal estimate is low by at most one
            speed_reg <= sat_reg ? RPM_MAX : r0 + SPEED_W'(remd >= RPM_DIV);
            steer_reg <= steer_f_reg;
        end
    end

    assign speed = speed_reg;
    assign steer = steer_reg;

endmodule

FILE: rtl/core/swerve_drive_wheel_kinematics_unit.sv
// Throughput: one word per cycle; stalls fill bubbles before holding the input.
// The pipeline is the 29-cell square root chain, one root bit per cell,
// plus 4 front-end and 3 rpm scaling stages.
// Reset clears all valid bits and loads the geometry, gain and offset defaults.
`include "assert_macros.svh"

module swerve_drive_wheel_kinematics_unit
    import swk_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [CFG_DATA_W-1:0]    cfg_data,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic signed [VEL_W-1:0]  vel_x_mm_s,
    input  logic signed [VEL_W-1:0]  vel_y_mm_s,
    input  logic signed [VEL_W-1:0]  yaw_rate_mrad_s,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [SPEED_W-1:0]       speed_front_right,
    output logic [SPEED_W-1:0]       speed_front_left,
    output logic [SPEED_W-1:0]       speed_rear_left,
    output logic [SPEED_W-1:0]       speed_rear_right,
    output logic [STEER_W-1:0]       steer_front_right,
    output logic [STEER_W-1:0]       steer_front_left,
    output logic [STEER_W-1:0]       steer_rear_left,
    output logic [STEER_W-1:0]       steer_rear_right
);

    logic [DIM_W-1:0]       half_wheelbase_reg, half_track_reg;
    logic [GAIN_W-1:0]      gain_reg;
    logic [OFFSET_W-1:0]    offset_reg [NUM_WHEELS];
    logic [PIPE_STAGES-1:0] valid_reg, valid_next, en;
    cell_data_t             head [NUM_WHEELS];
    cell_data_t             chain [NUM_WHEELS][SQRT_STAGES+1];
    logic [SPEED_W-1:0]     speed [NUM_WHEELS];
    logic [STEER_W-1:0]     steer [NUM_WHEELS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_wheelbase_reg <= 12'd200;
            half_track_reg     <= 12'd200;
            gain_reg           <= 20'd8237;
            for (int w = 0; w < NUM_WHEELS; w++)
            begin
                offset_reg[w] <= '0;
            end
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_HALF_WHEELBASE: half_wheelbase_reg <= cfg_data[DIM_W-1:0];
                REG_HALF_TRACK:     half_track_reg     <= cfg_data[DIM_W-1:0];
                REG_RPM_GAIN:       gain_reg           <= cfg_data[GAIN_W-1:0];
                REG_OFFSET_FR:      offset_reg[0]      <= cfg_data[OFFSET_W-1:0];
                REG_OFFSET_FL:      offset_reg[1]      <= cfg_data[OFFSET_W-1:0];
                REG_OFFSET_RL:      offset_reg[2]      <= cfg_data[OFFSET_W-1:0];
                REG_OFFSET_RR:      offset_reg[3]      <= cfg_data[OFFSET_W-1:0];
                default:            ;
            endcase
        end
    end

    // a stage advances when it is empty or the one after it advances
    always_comb
    begin
        en[PIPE_STAGES-1] = !valid_reg[PIPE_STAGES-1] || out_ready;
        for (int i = PIPE_STAGES - 2; i >= 0; i--)
        begin
            en[i] = !valid_reg[i] || en[i+1];
        end
        valid_next[0] = en[0] ? in_valid : valid_reg[0];
        for (int i = 1; i < PIPE_STAGES; i++)
        begin
            valid_next[i] = en[i] ? valid_reg[i-1] : valid_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign in_ready  = en[0];
    assign out_valid = valid_reg[PIPE_STAGES-1];

    swk_front u_front (
        .clk             (clk),
        .en              (en[FRONT_STAGES-1:0]),
        .vel_x_mm_s      (vel_x_mm_s),
        .vel_y_mm_s      (vel_y_mm_s),
        .yaw_rate_mrad_s (yaw_rate_mrad_s),
        .half_wheelbase  (half_wheelbase_reg),
        .half_track      (half_track_reg),
        .head            (head)
    );

    for (genvar w = 0; w < NUM_WHEELS; w++)
    begin : g_wheel
        assign chain[w][0] = head[w];

        for (genvar j = 0; j < SQRT_STAGES; j++)
        begin : g_cell
            swk_cell u_cell (
                .clk   (clk),
                .en    (en[FRONT_STAGES + j]),
                .stage (SHIFT_W'(j)),
                .d_in  (chain[w][j]),
                .d_out (chain[w][j+1])
            );
        end

        swk_back u_back (
            .clk    (clk),
            .en     (en[PIPE_STAGES-1 -: BACK_STAGES]),
            .d_in   (chain[w][SQRT_STAGES]),
            .gain   (gain_reg),
            .offset (offset_reg[w]),
            .speed  (speed[w]),
            .steer  (steer[w])
        );
    end

    assign speed_front_right = speed[0];
    assign speed_front_left  = speed[1];
    assign speed_rear_left   = speed[2];
    assign speed_rear_right  = speed[3];
    assign steer_front_right = steer[0];
    assign steer_front_left  = steer[1];
    assign steer_rear_left   = steer[2];
    assign steer_rear_right  = steer[3];

    `SWK_ASSERT_ALWAYS(a_full_when_blocked, !in_ready |-> (&valid_reg), "input blocked with a bubble in the pipe")
    `SWK_ASSERT(a_accept_enters, (in_valid && in_ready) |=> valid_reg[0], "accepted word did not enter the first stage")
    `SWK_ASSERT(a_stall_holds, (out_valid && !out_ready) |=> (out_valid && $stable(speed_front_right) && $stable(steer_rear_right)), "stalled output word changed")

endmodule
